// ----- hdl/tps_pkg.sv -----
// Package for the triangle pixel shader: screen defaults, op codes, state types.
// No dependencies.
`timescale 1ns / 1ps
package tps_pkg;
   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;
   localparam logic [31:0] DEPTH_FLOOR = 32'h8000_0000;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SHADE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_AREA, ST_EDGE, ST_DIV, ST_DEPTH, ST_SCALE, ST_COLOUR,
      ST_ROUND, ST_TEST, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

// ----- hdl/triangle_pixel_shader.sv -----
// Triangle pixel shader top level: corner registers, sequencer, pixel stores.
// Depends on tps_pkg, tps_ram, tps_div.
// Load, read and off-screen shade go from idle straight to the done state; an uncovered
// shade runs the area and edge steps; a covered shade adds three divisions in the shared
// divider plus depth, colour, rounding and test steps. One item at a time; busy is high
// while an item is at work; the receiver cannot stall. Reset clears the corners, then
// sweeps both stores one pixel a cycle.
`timescale 1ns / 1ps
module triangle_pixel_shader #(
   parameter int SCREEN_WIDTH  = tps_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tps_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [1:0]         req_vertex_slot,
   input  logic signed [11:0] req_vert_x,
   input  logic signed [11:0] req_vert_y,
   input  logic signed [31:0] req_vert_z,
   input  logic [23:0]        req_vert_color,
   input  logic [8:0]         req_pixel_x,
   input  logic [7:0]         req_pixel_y,
   output logic               rsp_strobe,
   output logic               rsp_pixel_written,
   output logic [23:0]        rsp_pixel_color,
   output logic signed [31:0] rsp_stored_depth
);
   import tps_pkg::*;
   localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW = $clog2(PIXELS);
   localparam logic [33:0] RECIP_THIRD = 34'd11453246123;

   state_type state_ff, state_in;
   logic signed [11:0] cx_ff [3];
   logic signed [11:0] cy_ff [3];
   logic signed [31:0] cz_ff [3];
   logic [23:0]        cc_ff [3];

   logic        inside_ff;
   logic [AW-1:0] addr_ff, addr_in;
   logic signed [11:0] px_ff, py_ff;
   logic [AW-1:0] clr_ff;
   logic signed [25:0] area_ff, e_ff [3], t_ff [3];
   logic [1:0]  idx_ff, idx_in;
   logic [16:0] w_ff [3];
   logic signed [50:0] prod_ff [3];
   logic signed [52:0] sum_ff;
   logic [32:0] dmag_ff;
   logic        dneg_ff;
   logic signed [31:0] depth_ff;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic        cov, wr_ff;

   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [23:0] col_wd, col_rd;
   logic [31:0] dep_wd, dep_rd;
   div_req_type div_req;
   logic        div_done;
   logic [47:0] div_q;

   function automatic logic signed [25:0] edge_f(
      input logic signed [11:0] px, py, ax, ay, bx, by);
      logic signed [25:0] s;
      s = 26'(($signed({ay[11], ay}) - by) * px) + 26'(($signed({bx[11], bx}) - ax) * py)
         + 26'(ax * by) - 26'(bx * ay);
      return s;
   endfunction

   function automatic logic [25:0] mag(input logic signed [25:0] v);
      return v[25] ? 26'(-v) : 26'(v);
   endfunction

   tps_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_frame (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(col_wd), .rd_data(col_rd));
   tps_ram #(.WIDTH(32), .DEPTH(PIXELS)) u_depth (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr), .wr_data(dep_wd), .rd_data(dep_rd));
   tps_div u_div (.clock(clock), .reset(reset), .req(div_req), .done(div_done),
      .quotient(div_q));

   logic accept;
   logic inside_c;
   assign accept = start && !busy;
   assign inside_c = (32'(req_pixel_x) < SCREEN_WIDTH) && (32'(req_pixel_y) < SCREEN_HEIGHT);
   assign addr_in = inside_c ?
      AW'(32'(req_pixel_y) * SCREEN_WIDTH + 32'(req_pixel_x)) : '0;

   logic [16:0] w_sat;
   assign w_sat = (div_q > 48'd65536) ? 17'd65536 : div_q[16:0];

   logic depth_pass;
   assign depth_pass = ($signed(dep_rd) <= depth_ff);

   // divide the Q.16 depth sum by 3*65536: shift, then reciprocal of three
   logic [52:0] sum_mag;
   logic [33:0] sum_hi;
   logic [67:0] recip_prod;
   assign sum_mag = sum_ff[52] ? 53'(-sum_ff) : 53'(sum_ff);
   assign sum_hi = 34'(sum_mag >> 16);
   assign recip_prod = 68'(sum_hi) * 68'(RECIP_THIRD);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (32'(clr_ff) == PIXELS - 1) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = (req_op == OP_SHADE && inside_c) ? ST_AREA
                                            : ST_DONE;
         ST_AREA:   state_in = ST_EDGE;
         ST_EDGE:   state_in = cov ? ST_DIV : ST_DONE;
         ST_DIV:    if (div_done && idx_ff == 2'd2) state_in = ST_DEPTH;
         ST_DEPTH:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_COLOUR;
         ST_COLOUR: state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_TEST;
         ST_TEST:   state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = (state_ff != ST_IDLE);
      mem_we = 1'b0;
      mem_addr = addr_ff;
      col_wd = {r_ff, g_ff, b_ff};
      dep_wd = depth_ff;
      div_req = '0;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = clr_ff;
            col_wd = '0;
            dep_wd = DEPTH_FLOOR;
         end
         ST_IDLE: mem_addr = addr_in;
         ST_EDGE: begin
            idx_in = 2'd0;
            div_req.start = cov;
            div_req.dividend = {6'd0, mag(e_ff[0]), 16'd0};
            div_req.divisor = {6'd0, mag(area_ff)};
         end
         ST_DIV: if (div_done && idx_ff != 2'd2) begin
            idx_in = idx_ff + 2'd1;
            div_req.start = 1'b1;
            div_req.dividend = {6'd0, mag(e_ff[idx_ff + 2'd1]), 16'd0};
            div_req.divisor = {6'd0, mag(area_ff)};
         end
         ST_TEST: mem_we = wr_ff && depth_pass;
         default: ;
      endcase
   end

   logic signed [26:0] a0;
   logic [2:0] pos, tie, neg;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = (e_ff[i] != 0) && (e_ff[i][25] == area_ff[25]);
         neg[i] = (e_ff[i] != 0) && (e_ff[i][25] != area_ff[25]);
         tie[i] = (t_ff[i] != 0) && (t_ff[i][25] == area_ff[25]);
      end
      a0 = 27'(area_ff);
      cov = (a0 != 0) && (neg == 3'b000) && ((pos | tie) == 3'b111);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         idx_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
            cz_ff[i] <= '0;
            cc_ff[i] <= '0;
         end
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rsp_strobe <= (state_ff == ST_DONE);
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (accept && req_op == OP_LOAD && req_vertex_slot != 2'd3) begin
            cx_ff[req_vertex_slot] <= req_vert_x;
            cy_ff[req_vertex_slot] <= req_vert_y;
            cz_ff[req_vertex_slot] <= req_vert_z;
            cc_ff[req_vertex_slot] <= req_vert_color;
         end
      end
      if (accept) begin
         inside_ff <= inside_c;
         addr_ff <= addr_in;
         px_ff <= 12'(req_pixel_x);
         py_ff <= 12'(req_pixel_y);
         wr_ff <= 1'b0;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= edge_f(cx_ff[0], cy_ff[0], cx_ff[1], cy_ff[1], cx_ff[2], cy_ff[2]);
         for (int i = 0; i < 3; i++) begin
            e_ff[i] <= edge_f(px_ff, py_ff, cx_ff[(i+1)%3], cy_ff[(i+1)%3],
                              cx_ff[(i+2)%3], cy_ff[(i+2)%3]);
            t_ff[i] <= edge_f(12'sd0, 12'sd0, cx_ff[(i+1)%3], cy_ff[(i+1)%3],
                              cx_ff[(i+2)%3], cy_ff[(i+2)%3]);
         end
      end
      if (state_ff == ST_DIV && div_done) w_ff[idx_ff] <= w_sat;
      if (state_ff == ST_DEPTH) begin
         for (int i = 0; i < 3; i++) prod_ff[i] <= $signed({1'b0, w_ff[i]}) * cz_ff[i];
      end
      if (state_ff == ST_SCALE) begin
         sum_ff <= 53'(prod_ff[0]) + 53'(prod_ff[1]) + 53'(prod_ff[2]);
         r_ff <= 8'((25'(cc_ff[0][23:16]) * w_ff[0]) >> 16)
               + 8'((25'(cc_ff[1][23:16]) * w_ff[1]) >> 16)
               + 8'((25'(cc_ff[2][23:16]) * w_ff[2]) >> 16);
         g_ff <= 8'((25'(cc_ff[0][15:8]) * w_ff[0]) >> 16)
               + 8'((25'(cc_ff[1][15:8]) * w_ff[1]) >> 16)
               + 8'((25'(cc_ff[2][15:8]) * w_ff[2]) >> 16);
         b_ff <= 8'((25'(cc_ff[0][7:0]) * w_ff[0]) >> 16)
               + 8'((25'(cc_ff[1][7:0]) * w_ff[1]) >> 16)
               + 8'((25'(cc_ff[2][7:0]) * w_ff[2]) >> 16);
      end
      if (state_ff == ST_COLOUR) begin
         dmag_ff <= recip_prod[67:35];
         dneg_ff <= sum_ff[52];
         wr_ff <= 1'b1;
      end
      if (state_ff == ST_ROUND) begin
         // truncate toward zero, then saturate
         if (!dneg_ff && dmag_ff > 33'h0_7fff_ffff) depth_ff <= 32'sh7fff_ffff;
         else if (dneg_ff && dmag_ff > 33'h0_8000_0000) depth_ff <= 32'sh8000_0000;
         else depth_ff <= dneg_ff ? 32'(-dmag_ff) : dmag_ff[31:0];
      end
      if (state_ff == ST_TEST) wr_ff <= wr_ff && depth_pass;
      if (state_ff == ST_DONE) begin
         rsp_pixel_written <= wr_ff;
         if (!inside_ff) begin
            rsp_pixel_color <= '0;
            rsp_stored_depth <= '0;
         end else if (wr_ff) begin
            rsp_pixel_color <= {r_ff, g_ff, b_ff};
            rsp_stored_depth <= depth_ff;
         end else begin
            rsp_pixel_color <= col_rd;
            rsp_stored_depth <= dep_rd;
         end
      end
   end
endmodule

// ----- hdl/tps_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ----- hdl/tps_div.sv -----
// Restoring divider, one quotient bit per cycle: 48-bit dividend over 32-bit divisor.
// Depends on tps_pkg.
`timescale 1ns / 1ps
module tps_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tps_pkg::div_req_type req,
   output logic                 done,
   output logic [47:0]          quotient
);
   import tps_pkg::*;
   logic [47:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = '0;
      done_in = busy_ff && (cnt_ff == 6'd1);
      if (req.start) begin
         q_in = req.dividend;
         rem_in = '0;
         den_in = req.divisor;
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff[31:0], q_ff[47]};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   assign quotient = q_ff;
   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule

// ----- hdl/tps_checker.sv -----
// Port checker for the triangle pixel shader, bound to the top level.
// Depends on triangle_pixel_shader.
`timescale 1ns / 1ps
module tps_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_pixel_written
);
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double strobe");
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("strobe without work");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept without busy");
   a_written_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_pixel_written) |-> $past(busy, 2)) else $error("write flag");
endmodule

bind triangle_pixel_shader tps_checker u_tps_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_pixel_written(rsp_pixel_written));

// ----- tb/sv/triangle_pixel_shader_tb.sv -----
// Self-checking testbench for triangle_pixel_shader: directed and random corner loads,
// shades and reads, with a scoreboard that predicts the stored colour and depth per pixel.
// Depends on tps_pkg and the triangle_pixel_shader RTL.
`timescale 1ns / 1ps

class shade_scoreboard;
   localparam int WIDTH  = tps_pkg::SCREEN_WIDTH_DEF;
   localparam int HEIGHT = tps_pkg::SCREEN_HEIGHT_DEF;

   typedef struct {
      bit        written;
      bit [23:0] colour;
      bit [31:0] depth;
   } pixel_result_type;

   longint    corner_x[3];
   longint    corner_y[3];
   bit [31:0] corner_z[3];
   bit [23:0] corner_rgb[3];
   bit [23:0] colour_mem[WIDTH*HEIGHT];
   bit [31:0] depth_mem[WIDTH*HEIGHT];
   pixel_result_type pending_pixels[$];
   int errors;
   int n_written;
   int n_results;

   function new();
      for (int i = 0; i < 3; i++) begin
         corner_x[i] = 0;
         corner_y[i] = 0;
         corner_z[i] = 0;
         corner_rgb[i] = 0;
      end
      for (int i = 0; i < WIDTH*HEIGHT; i++) begin
         colour_mem[i] = 0;
         depth_mem[i] = tps_pkg::DEPTH_FLOOR;
      end
      errors = 0;
      n_written = 0;
      n_results = 0;
   endfunction

   function longint edge_val(longint px, longint py, longint ax, longint ay,
                             longint bx, longint by);
      return (ay - by) * px + (bx - ax) * py + ax * by - bx * ay;
   endfunction

   function int sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function bit shade(int idx, longint px, longint py);
      longint area, sum, depth, r, g, b;
      longint e[3], t[3], w[3];
      int sa, a, c;
      area = edge_val(corner_x[0], corner_y[0], corner_x[1], corner_y[1],
                      corner_x[2], corner_y[2]);
      sa = sgn(area);
      sum = 0;
      r = 0;
      g = 0;
      b = 0;
      if (sa == 0) return 0;
      for (int i = 0; i < 3; i++) begin
         a = (i + 1) % 3;
         c = (i + 2) % 3;
         e[i] = edge_val(px, py, corner_x[a], corner_y[a], corner_x[c], corner_y[c]);
         t[i] = edge_val(0, 0, corner_x[a], corner_y[a], corner_x[c], corner_y[c]);
         if (e[i] != 0 && sgn(e[i]) != sa) return 0;
      end
      for (int i = 0; i < 3; i++)
         if (e[i] == 0 && !(t[i] != 0 && sgn(t[i]) == sa)) return 0;
      for (int i = 0; i < 3; i++) begin
         w[i] = (mag(e[i]) << 16) / mag(area);
         if (w[i] > 65536) w[i] = 65536;
         sum += w[i] * longint'($signed(corner_z[i]));
      end
      depth = sum / (3 * 65536);
      if (depth > 64'sd2147483647) depth = 64'sd2147483647;
      if (depth < -64'sd2147483648) depth = -64'sd2147483648;
      if (longint'($signed(depth_mem[idx])) > depth) return 0;
      for (int i = 0; i < 3; i++) begin
         r += (longint'(corner_rgb[i][23:16]) * w[i]) >> 16;
         g += (longint'(corner_rgb[i][15:8]) * w[i]) >> 16;
         b += (longint'(corner_rgb[i][7:0]) * w[i]) >> 16;
      end
      depth_mem[idx] = depth[31:0];
      colour_mem[idx] = {r[7:0], g[7:0], b[7:0]};
      return 1;
   endfunction

   function void note_transfer(bit [1:0] op, bit [1:0] slot, bit [11:0] x, bit [11:0] y,
                               bit [31:0] z, bit [23:0] rgb, bit [8:0] px, bit [7:0] py);
      pixel_result_type res;
      bit on_screen;
      int idx;
      on_screen = (px < WIDTH) && (py < HEIGHT);
      idx = on_screen ? int'(py) * WIDTH + int'(px) : 0;
      res.written = 0;
      if (op == tps_pkg::OP_LOAD) begin
         if (slot < 3) begin
            corner_x[slot] = longint'($signed(x));
            corner_y[slot] = longint'($signed(y));
            corner_z[slot] = z;
            corner_rgb[slot] = rgb;
         end
      end else if (op == tps_pkg::OP_SHADE && on_screen) begin
         res.written = shade(idx, px, py);
      end
      res.colour = on_screen ? colour_mem[idx] : 24'd0;
      res.depth = on_screen ? depth_mem[idx] : 32'd0;
      pending_pixels.insert(pending_pixels.size(), res);
   endfunction

   function void check_result(bit written, bit [23:0] colour, bit [31:0] depth);
      pixel_result_type exp_res;
      n_results++;
      if (pending_pixels.size() == 0) begin
         $display("%0t: unexpected result written=%0b colour=%h depth=%h",
                  $time, written, colour, depth);
         errors++;
         return;
      end
      exp_res = pending_pixels.pop_front();
      if (written) n_written++;
      if (written !== exp_res.written) begin
         $display("%0t: pixel_written expected %0b got %0b", $time, exp_res.written, written);
         errors++;
      end
      if (colour !== exp_res.colour) begin
         $display("%0t: pixel_color expected %h got %h", $time, exp_res.colour, colour);
         errors++;
      end
      if (depth !== exp_res.depth) begin
         $display("%0t: stored_depth expected %h got %h", $time, exp_res.depth, depth);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_pixels.size();
   endfunction
endclass

module triangle_pixel_shader_tb;
   import tps_pkg::*;

   localparam logic [1:0] OP_SPARE  = 2'd3;
   localparam logic [1:0] SLOT_NONE = 2'd3;
   localparam int ITEMS = 850;
   localparam int STALL_LIMIT = 400000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic [1:0]         req_vertex_slot;
   logic signed [11:0] req_vert_x;
   logic signed [11:0] req_vert_y;
   logic signed [31:0] req_vert_z;
   logic [23:0]        req_vert_color;
   logic [8:0]         req_pixel_x;
   logic [7:0]         req_pixel_y;
   logic               rsp_strobe;
   logic               rsp_pixel_written;
   logic [23:0]        rsp_pixel_color;
   logic signed [31:0] rsp_stored_depth;

   shade_scoreboard sb = new();
   int n_items;
   int n_shades;
   int idle_cycles;
   int tri_x[3];
   int tri_y[3];

   triangle_pixel_shader i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_vertex_slot(req_vertex_slot),
      .req_vert_x(req_vert_x), .req_vert_y(req_vert_y), .req_vert_z(req_vert_z),
      .req_vert_color(req_vert_color), .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y), .rsp_strobe(rsp_strobe),
      .rsp_pixel_written(rsp_pixel_written), .rsp_pixel_color(rsp_pixel_color),
      .rsp_stored_depth(rsp_stored_depth)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result(rsp_pixel_written, rsp_pixel_color, rsp_stored_depth);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic send(logic [1:0] op, logic [1:0] slot, logic [11:0] x, logic [11:0] y,
                       logic [31:0] z, logic [23:0] rgb, logic [8:0] px, logic [7:0] py);
      int gap;
      req_op <= op;
      req_vertex_slot <= slot;
      req_vert_x <= x;
      req_vert_y <= y;
      req_vert_z <= z;
      req_vert_color <= rgb;
      req_pixel_x <= px;
      req_pixel_y <= py;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_transfer(op, slot, x, y, z, rgb, px, py);
      n_items++;
      if (op == OP_SHADE) n_shades++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_corner(int slot, int x, int y, logic [31:0] z, logic [23:0] rgb);
      send(OP_LOAD, slot[1:0], x[11:0], y[11:0], z, rgb, $urandom_range(0, 511),
           $urandom_range(0, 255));
      if (slot < 3) begin
         tri_x[slot] = x;
         tri_y[slot] = y;
      end
   endtask

   task automatic shade_at(int px, int py);
      send(OP_SHADE, $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom,
           px[8:0], py[7:0]);
   endtask

   task automatic random_triangle();
      int cx, cy, spread, x, y;
      logic [31:0] z;
      cx = $urandom_range(0, 319);
      cy = $urandom_range(0, 239);
      spread = ($urandom_range(0, 9) == 0) ? 1500 : 60;
      for (int i = 0; i < 3; i++) begin
         x = clamp(cx + $urandom_range(0, 2 * spread) - spread, -2048, 2047);
         y = clamp(cy + $urandom_range(0, 2 * spread) - spread, -2048, 2047);
         if ($urandom_range(0, 3) == 0) z = $urandom;
         else z = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         load_corner(i, x, y, z, $urandom);
      end
   endtask

   task automatic shade_in_triangle();
      int lox, hix, loy, hiy;
      lox = clamp(tri_x[0] < tri_x[1] ? tri_x[0] : tri_x[1], 0, 319);
      lox = clamp(tri_x[2] < lox ? tri_x[2] : lox, 0, 319);
      hix = clamp(tri_x[0] > tri_x[1] ? tri_x[0] : tri_x[1], 0, 319);
      hix = clamp(tri_x[2] > hix ? tri_x[2] : hix, lox, 319);
      loy = clamp(tri_y[0] < tri_y[1] ? tri_y[0] : tri_y[1], 0, 239);
      loy = clamp(tri_y[2] < loy ? tri_y[2] : loy, 0, 239);
      hiy = clamp(tri_y[0] > tri_y[1] ? tri_y[0] : tri_y[1], 0, 239);
      hiy = clamp(tri_y[2] > hiy ? tri_y[2] : hiy, loy, 239);
      if ($urandom_range(0, 4) == 0)
         shade_at(tri_x[$urandom_range(0, 2)] & 511, tri_y[$urandom_range(0, 2)] & 255);
      else
         shade_at($urandom_range(lox, hix), $urandom_range(loy, hiy));
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 4))
         0: send(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
         1: send(OP_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
         2: send(OP_LOAD, SLOT_NONE, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
         3: shade_at($urandom_range(0, 511), $urandom_range(0, 255));
         default: load_corner($urandom_range(0, 2), $urandom_range(0, 4095) - 2048,
                              $urandom_range(0, 4095) - 2048, $urandom, $urandom);
      endcase
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_READ;
      req_vertex_slot = 0;
      req_vert_x = 0;
      req_vert_y = 0;
      req_vert_z = 0;
      req_vert_color = 0;
      req_pixel_x = 0;
      req_pixel_y = 0;
      idle_cycles = 0;
      n_items = 0;
      n_shades = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: cleared stores, plain triangle, depth test, winding, corner cases
      send(OP_READ, 0, 0, 0, 0, 0, 9'd319, 8'd239);
      load_corner(0, 10, 10, 32'h0001_0000, 24'hff0000);
      load_corner(1, 200, 20, 32'h0002_0000, 24'h00ff00);
      load_corner(2, 50, 180, 32'h0003_0000, 24'h0000ff);
      shade_at(60, 60);
      shade_at(10, 10);
      shade_at(105, 15);
      load_corner(0, 10, 10, 32'h8000_0000, 24'hffffff);
      shade_at(60, 60);
      load_corner(1, 50, 180, 32'h7fff_ffff, 24'hffffff);
      load_corner(2, 200, 20, 32'h7fff_ffff, 24'hffffff);
      shade_at(60, 60);
      load_corner(0, -2048, -2048, 32'h7fff_ffff, 24'h000000);
      load_corner(1, 2047, -2048, 32'h7fff_ffff, 24'h808080);
      load_corner(2, 0, 2047, 32'h7fff_ffff, 24'hffffff);
      shade_at(0, 0);
      shade_at(319, 239);
      shade_at(511, 255);
      load_corner(2, 0, -2048, 0, 0);
      shade_at(5, 5);
      send(OP_LOAD, SLOT_NONE, 12'h7ff, 12'h800, 0, 24'h123456, 0, 0);
      send(OP_SPARE, 0, 0, 0, 0, 0, 9'd60, 8'd60);
      send(OP_READ, 0, 0, 0, 0, 0, 9'd320, 8'd240);

      while (n_items < ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            noise_item();
         end else begin
            random_triangle();
            repeat ($urandom_range(2, 8)) begin
               if ($urandom_range(0, 5) == 0)
                  send(OP_READ, 0, 0, 0, 0, 0, $urandom_range(0, 319), $urandom_range(0, 239));
               else
                  shade_in_triangle();
            end
         end
      end
      start <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d transfers, %0d shades, %0d results, %0d pixels written.",
               n_items, n_shades, sb.n_results, sb.n_written);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- triangle_pixel_shader.f -----
hdl/tps_pkg.sv
hdl/tps_ram.sv
hdl/tps_div.sv
hdl/triangle_pixel_shader.sv
hdl/tps_checker.sv
tb/sv/triangle_pixel_shader_tb.sv
